// File: src/mbi_pkg.sv
// ============================================================================
// mbi_pkg: shared types and constants for the MurmurHash2 bucket index block
// Holds the queue entry layout, the operation codes and the mixing constants.
// ============================================================================
package mbi_pkg;

    // Mixing constants of the 32-bit MurmurHash2 definition.
    localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Kind of work that an item asks of the back end.
    typedef logic [1:0] op_kind_t;
    localparam op_kind_t OP_NONE = 2'd0;   // no key bytes
    localparam op_kind_t OP_TAIL = 2'd1;   // one to three tail bytes
    localparam op_kind_t OP_WORD = 2'd2;   // a full four-byte word

    // One classified item as it travels through the queue.
    typedef struct packed {
        op_kind_t    kind;
        logic [31:0] word;       // full word, or tail bytes already masked
        logic [31:0] init_hash;  // seed XOR key length, used on a first item
        logic        first;
        logic        last;
    } entry_t;

endpackage

// File: src/mbi_front.sv
// ============================================================================
// mbi_front: input classifier
// Accepts items, clamps the key length, masks tail bytes and picks the
// operation kind, then pushes one entry into the queue.
// ============================================================================
module mbi_front #(
    parameter logic [31:0] MAX_KEY_BYTES = 32'd65535
) (
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [31:0]     key_word,
    input  logic [2:0]      valid_bytes,
    input  logic [15:0]     key_length,
    input  logic            first_item,
    input  logic            last_item,
    input  logic [31:0]     seed,
    input  logic            queue_full,
    output logic            push,
    output mbi_pkg::entry_t push_entry
);

    logic [31:0] len_ext;
    logic [15:0] len_clamped;

    // An item is taken whenever the queue has room.
    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    // Clamp the key length to the largest supported key.
    assign len_ext     = {16'd0, key_length};
    assign len_clamped = (len_ext > MAX_KEY_BYTES) ? MAX_KEY_BYTES[15:0] : key_length;

    // Classify the item and keep only the bytes that are valid.
    always_comb
    begin
        push_entry.init_hash = seed ^ {16'd0, len_clamped};
        push_entry.first     = first_item;
        push_entry.last      = last_item;
        case (valid_bytes)
            3'd0:
            begin
                push_entry.kind = mbi_pkg::OP_NONE;
                push_entry.word = 32'd0;
            end
            3'd1:
            begin
                push_entry.kind = mbi_pkg::OP_TAIL;
                push_entry.word = key_word & 32'h0000_00ff;
            end
            3'd2:
            begin
                push_entry.kind = mbi_pkg::OP_TAIL;
                push_entry.word = key_word & 32'h0000_ffff;
            end
            3'd3:
            begin
                push_entry.kind = mbi_pkg::OP_TAIL;
                push_entry.word = key_word & 32'h00ff_ffff;
            end
            default:
            begin
                // Four or more valid bytes count as a full word.
                push_entry.kind = mbi_pkg::OP_WORD;
                push_entry.word = key_word;
            end
        endcase
    end

endmodule

// File: src/mbi_queue.sv
// ============================================================================
// mbi_queue: short queue between front and back
// A small first-in first-out buffer of classified entries.
// ============================================================================
module mbi_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mbi_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output mbi_pkg::entry_t head_entry
);

    mbi_pkg::entry_t                  slot_reg [mbi_pkg::QUEUE_DEPTH];
    logic [mbi_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [mbi_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [mbi_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             do_push, do_pop;

    assign full       = (count_reg == mbi_pkg::QCNT_W'(mbi_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == mbi_pkg::QPTR_W'(mbi_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mbi_pkg::QPTR_W'(mbi_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: src/mbi_back.sv
// ============================================================================
// mbi_back: hash sequencer
// Runs the word mix, tail mix and final mix on one shared multiplier and
// holds the running hash and the result register.
// ============================================================================
module mbi_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     index_mask,
    input  logic            head_valid,
    input  mbi_pkg::entry_t head_entry,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [31:0]     bucket_index,
    output logic [31:0]     full_hash
);

    localparam logic [2:0] ST_IDLE = 3'd0;   // take the next entry
    localparam logic [2:0] ST_K2   = 3'd1;   // second multiply of the word
    localparam logic [2:0] ST_K3   = 3'd2;   // hash multiply and combine
    localparam logic [2:0] ST_F1   = 3'd3;   // final mix multiply
    localparam logic [2:0] ST_F2   = 3'd4;   // final shift and result load

    logic [2:0]  state_reg, state_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] k_reg, k_next;
    logic        last_reg, last_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] bucket_reg, bucket_next;
    logic [31:0] full_reg, full_next;

    logic [31:0] hash_start;
    logic [31:0] mul_a;
    logic [31:0] product;
    logic [31:0] hash_final;
    logic        out_free;

    assign hash_start = head_entry.first ? head_entry.init_hash : hash_reg;
    assign hash_final = hash_reg ^ (hash_reg >> mbi_pkg::FIN_SHIFT_B);
    assign out_free   = !out_valid_reg || out_ready;
    assign pop        = (state_reg == ST_IDLE) && head_valid;

    // Operand select for the shared multiplier.
    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (head_entry.kind == mbi_pkg::OP_WORD)
                begin
                    mul_a = head_entry.word;
                end
                else
                begin
                    mul_a = hash_start ^ head_entry.word;
                end
            end
            ST_K2:   mul_a = k_reg ^ (k_reg >> mbi_pkg::MIX_SHIFT);
            ST_K3:   mul_a = hash_reg;
            ST_F1:   mul_a = hash_reg ^ (hash_reg >> mbi_pkg::FIN_SHIFT_A);
            default: mul_a = hash_reg;
        endcase
    end

    assign product = mul_a * mbi_pkg::MIX_MUL;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        k_next         = k_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        bucket_next    = bucket_reg;
        full_next      = full_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    last_next = head_entry.last;
                    case (head_entry.kind)
                        mbi_pkg::OP_WORD:
                        begin
                            hash_next  = hash_start;
                            k_next     = product;
                            state_next = ST_K2;
                        end
                        mbi_pkg::OP_TAIL:
                        begin
                            hash_next  = product;
                            state_next = head_entry.last ? ST_F1 : ST_IDLE;
                        end
                        default:
                        begin
                            hash_next  = hash_start;
                            state_next = head_entry.last ? ST_F1 : ST_IDLE;
                        end
                    endcase
                end
            end
            ST_K2:
            begin
                k_next     = product;
                state_next = ST_K3;
            end
            ST_K3:
            begin
                hash_next  = product ^ k_reg;
                state_next = last_reg ? ST_F1 : ST_IDLE;
            end
            ST_F1:
            begin
                hash_next  = product;
                state_next = ST_F2;
            end
            ST_F2:
            begin
                // Wait here until the result register is free.
                if (out_free)
                begin
                    hash_next      = hash_final;
                    full_next      = hash_final;
                    bucket_next    = hash_final & index_mask;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hash_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload.
    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        last_reg   <= last_next;
        bucket_reg <= bucket_next;
        full_reg   <= full_next;
    end

    assign out_valid    = out_valid_reg;
    assign bucket_index = bucket_reg;
    assign full_hash    = full_reg;

    // The second step of the word mix is always followed by its third step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_K2) |=> (state_reg == ST_K3))
        else $error("word mix left its second step early");

    // The final mix always reaches the result step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_F1) |=> (state_reg == ST_F2))
        else $error("final mix skipped its result step");

    // Entries are taken only between items.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE))
        else $error("entry taken while an item is in progress");

    // A new result appears only from the result step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_F2))
        else $error("result raised outside the result step");

endmodule

// File: src/murmur2_bucket_index.sv
// ============================================================================
// murmur2_bucket_index: MurmurHash2 bucket index
// Hashes a key streamed as 32-bit words and reduces the hash to a bucket.
// ============================================================================
// Usage:
//   Items enter on the in_valid / in_ready channel, one little-endian key word
//   each. The first item of a key carries first_item and the key length; the
//   last carries last_item and may hold one to three tail bytes. A key with no
//   bytes is a single item marked first and last with valid_bytes zero.
//   Each last item gives one result (full_hash, bucket_index) on the
//   out_valid / out_ready channel; other items give none.
// Sequencing: a full word runs the back-end states IDLE, K2 and K3, a tail or
//   empty item IDLE alone, and a last item then F1 and F2 for the final mix;
//   every multiplication goes through the one shared 32x32 multiplier in the
//   back end. The result is registered from F2; an item may first wait in the
//   two-entry queue.
// Reset clears the running hash to zero, seed to 5381 and index_mask to 1023.
// When the receiver stalls, the result is held in the output register, the
//   back end waits at its final step and the queue takes items until full.
//   seed and index_mask are written through the APB port at byte addresses
//   0 and 4; the user must do so only while the block is idle (not enforced).
// ============================================================================
module murmur2_bucket_index #(
    parameter logic [31:0] MAX_KEY_BYTES = 32'd65535
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] key_word,
    input  logic [2:0]  valid_bytes,
    input  logic [15:0] key_length,
    input  logic        first_item,
    input  logic        last_item,
    // Output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] bucket_index,
    output logic [31:0] full_hash
);

    localparam logic REG_SEED       = 1'b0;
    localparam logic REG_INDEX_MASK = 1'b1;

    logic [31:0]     seed_reg;
    logic [31:0]     mask_reg;
    logic            cfg_write;
    logic            push;
    logic            pop;
    logic            queue_full;
    logic            head_valid;
    mbi_pkg::entry_t push_entry;
    mbi_pkg::entry_t head_entry;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 32'd5381;
            mask_reg <= 32'd1023;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_SEED)
            begin
                seed_reg <= pwdata;
            end
            else
            begin
                mask_reg <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == REG_INDEX_MASK) ? mask_reg : seed_reg;

    // Front end: accept and classify.
    mbi_front #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .key_word    (key_word),
        .valid_bytes (valid_bytes),
        .key_length  (key_length),
        .first_item  (first_item),
        .last_item   (last_item),
        .seed        (seed_reg),
        .queue_full  (queue_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    // Queue between the two halves.
    mbi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Back end: hash sequencer and result register.
    mbi_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .index_mask   (mask_reg),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bucket_index (bucket_index),
        .full_hash    (full_hash)
    );

endmodule
